/* design/adsp_pkg.sv */
// Shared types, constants and helpers for the advertising-data structure parser.
package adsp_pkg;

  localparam int VENDOR_BYTES = 6;
  localparam int VIDX_W       = 3;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] NAME_TYPE_RST   = 8'h09;
  localparam logic [7:0] VENDOR_TYPE_RST = 8'hFF;
  localparam logic [7:0] MIN_VENDOR_RST  = 8'd8;

  typedef enum logic [1:0] {
    CFG_NAME_TYPE   = 2'd0,
    CFG_VENDOR_TYPE = 2'd1,
    CFG_MIN_VENDOR  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_NAME   = 2'd1,
    KIND_VENDOR = 2'd2,
    KIND_TRUNC  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       result_kind;
    logic [7:0]  record_type;
    logic [7:0]  record_length;
    logic        type_known;
    logic        too_short;
    logic [7:0]  name_char;
    logic [15:0] vendor_first_word;
    logic [15:0] vendor_second_word;
    logic [15:0] vendor_third_word;
    logic        last_of_run;
  } res_t;

  // Push request from the parser into the result queue.
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic is_known(input logic [7:0] t);
    is_known = (t == 8'h01) || (t == 8'h06) || (t == 8'h09) || (t == 8'hFF);
  endfunction

endpackage

/* design/adsp_out_queue.sv */
// Small result queue: takes up to two results per cycle, hands out one per beat.
module adsp_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  adsp_pkg::push_t     push,
  input  logic                pop,
  output adsp_pkg::res_t      head,
  output logic                head_valid,
  output logic                room_two
);

  adsp_pkg::res_t                   q_r   [adsp_pkg::QUEUE_DEPTH];
  adsp_pkg::res_t                   q_nxt [adsp_pkg::QUEUE_DEPTH];
  logic [adsp_pkg::QCNT_W-1:0]      cnt_r;
  logic [adsp_pkg::QCNT_W-1:0]      cnt_nxt;
  logic [adsp_pkg::QCNT_W-1:0]      cnt_after;

  assign head       = q_r[0];
  assign head_valid = (cnt_r != '0);
  assign room_two   = (cnt_r <= adsp_pkg::QCNT_W'(adsp_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    cnt_after = cnt_r - adsp_pkg::QCNT_W'(pop);
    for (int i = 0; i < adsp_pkg::QUEUE_DEPTH; i++) begin
      if (pop && (i < adsp_pkg::QUEUE_DEPTH - 1)) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      // New results land right behind whatever remains after the pop.
      if ((push.count != 2'd0) && (adsp_pkg::QCNT_W'(i) == cnt_after)) begin
        q_nxt[i] = push.first;
      end else if ((push.count == 2'd2) &&
                   (adsp_pkg::QCNT_W'(i) == cnt_after + adsp_pkg::QCNT_W'(1))) begin
        q_nxt[i] = push.second;
      end
    end
    cnt_nxt = cnt_after + adsp_pkg::QCNT_W'(push.count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= adsp_pkg::QCNT_W'(adsp_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> room_two)
    else $error("results pushed while the queue lacks room");

  a_push_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    push.count != 2'd3)
    else $error("more than two results pushed in one cycle");
`endif

endmodule

/* design/ad_structure_stream_parser.sv */
// Top level of the advertising-data structure parser: record walker and result queue.
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_stall   | in_data_byte, in_buffer_last
//   out     | out_valid / out_stall | out_result_kind ... out_last_of_run
//   cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each accepted byte is parsed in the cycle it is taken; its zero, one or two results
// enter a registered four-entry queue and appear on out one per beat unless out_stall.
// One byte per cycle is sustained while each byte yields at most one result and
// out_stall is low; a byte with two results grows the queue, as out holds one result.
// in_stall rises only when the queue cannot take two more results.
// Reset is synchronous; the configuration port is always ready.
module ad_structure_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_buffer_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_record_type,
  output logic [7:0]  out_record_length,
  output logic        out_type_known,
  output logic        out_too_short,
  output logic [7:0]  out_name_char,
  output logic [15:0] out_vendor_first_word,
  output logic [15:0] out_vendor_second_word,
  output logic [15:0] out_vendor_third_word,
  output logic        out_last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {
    PH_LEN     = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  logic [7:0] name_type_r, vendor_type_r, min_vendor_r;

  phase_t     phase_r, phase_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic [7:0] cur_type_r, cur_type_nxt;
  logic [7:0] cur_len_r, cur_len_nxt;
  logic [adsp_pkg::VIDX_W-1:0] idx_r, idx_nxt;
  logic [7:0] vb_r   [adsp_pkg::VENDOR_BYTES];
  logic [7:0] vb_nxt [adsp_pkg::VENDOR_BYTES];

  logic            in_acc;
  logic            done;
  logic            prim_v;
  logic            trunc_v;
  adsp_pkg::res_t  prim;
  adsp_pkg::res_t  trunc;
  adsp_pkg::push_t push;
  adsp_pkg::res_t  head;
  logic            head_valid;
  logic            room_two;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room_two;
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    phase_nxt    = phase_r;
    rem_nxt      = rem_r;
    cur_type_nxt = cur_type_r;
    cur_len_nxt  = cur_len_r;
    idx_nxt      = idx_r;
    vb_nxt       = vb_r;
    done         = 1'b0;
    prim_v       = 1'b0;
    prim         = '0;
    trunc_v      = 1'b0;
    trunc        = '0;

    case (phase_r)
      PH_TYPE: begin
        cur_type_nxt = in_data_byte;
        rem_nxt      = rem_r - 8'd1;
        idx_nxt      = '0;
        for (int i = 0; i < adsp_pkg::VENDOR_BYTES; i++) begin
          vb_nxt[i] = 8'd0;
        end
        prim_v             = 1'b1;
        prim.result_kind   = adsp_pkg::KIND_HEADER;
        prim.record_type   = in_data_byte;
        prim.record_length = cur_len_r;
        prim.type_known    = adsp_pkg::is_known(in_data_byte);
        prim.too_short     = (in_data_byte == vendor_type_r) &&
                             (in_data_byte != name_type_r) && (cur_len_r < min_vendor_r);
        done      = (rem_nxt == 8'd0);
        phase_nxt = done ? PH_LEN : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        rem_nxt = rem_r - 8'd1;
        done    = (rem_nxt == 8'd0);
        if (cur_type_r == name_type_r) begin
          prim_v             = 1'b1;
          prim.result_kind   = adsp_pkg::KIND_NAME;
          prim.record_type   = cur_type_r;
          prim.record_length = cur_len_r;
          prim.name_char     = in_data_byte;
        end else if ((cur_type_r == vendor_type_r) && (cur_len_r >= min_vendor_r)) begin
          if (idx_r < adsp_pkg::VIDX_W'(adsp_pkg::VENDOR_BYTES)) begin
            vb_nxt[idx_r] = in_data_byte;
            idx_nxt       = idx_r + adsp_pkg::VIDX_W'(1);
          end
          if (done) begin
            prim_v                  = 1'b1;
            prim.result_kind        = adsp_pkg::KIND_VENDOR;
            prim.record_type        = cur_type_r;
            prim.record_length      = cur_len_r;
            prim.vendor_first_word  = {vb_nxt[1], vb_nxt[0]};
            prim.vendor_second_word = {vb_nxt[3], vb_nxt[2]};
            prim.vendor_third_word  = {vb_nxt[5], vb_nxt[4]};
          end
        end
        if (done) begin
          phase_nxt = PH_LEN;
        end
      end
      default: begin
        if (in_data_byte == 8'd0) begin
          done      = 1'b1;
          phase_nxt = PH_LEN;
        end else begin
          cur_len_nxt  = in_data_byte;
          rem_nxt      = in_data_byte;
          cur_type_nxt = 8'd0;
          phase_nxt    = PH_TYPE;
        end
      end
    endcase

    // A buffer end inside a record closes it with a truncated result.
    if (in_buffer_last) begin
      trunc_v             = !done;
      trunc.result_kind   = adsp_pkg::KIND_TRUNC;
      trunc.record_type   = cur_type_nxt;
      trunc.record_length = cur_len_nxt;
      phase_nxt           = PH_LEN;
    end

    push.count  = in_acc ? (2'(prim_v) + 2'(trunc_v)) : 2'd0;
    push.first  = prim_v ? prim : trunc;
    push.second = trunc;
    push.first.last_of_run  = !(prim_v && trunc_v);
    push.second.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_LEN;
      rem_r         <= 8'd0;
      cur_type_r    <= 8'd0;
      cur_len_r     <= 8'd0;
      idx_r         <= '0;
      name_type_r   <= adsp_pkg::NAME_TYPE_RST;
      vendor_type_r <= adsp_pkg::VENDOR_TYPE_RST;
      min_vendor_r  <= adsp_pkg::MIN_VENDOR_RST;
    end else begin
      if (in_acc) begin
        phase_r    <= phase_nxt;
        rem_r      <= rem_nxt;
        cur_type_r <= cur_type_nxt;
        cur_len_r  <= cur_len_nxt;
        idx_r      <= idx_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          adsp_pkg::CFG_NAME_TYPE:   name_type_r   <= cfg_data;
          adsp_pkg::CFG_VENDOR_TYPE: vendor_type_r <= cfg_data;
          adsp_pkg::CFG_MIN_VENDOR:  min_vendor_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      vb_r <= vb_nxt;
    end
  end

  adsp_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (head_valid && !out_stall),
    .head       (head),
    .head_valid (head_valid),
    .room_two   (room_two)
  );

  assign out_valid              = head_valid;
  assign out_result_kind        = head.result_kind;
  assign out_record_type        = head.record_type;
  assign out_record_length      = head.record_length;
  assign out_type_known         = head.type_known;
  assign out_too_short          = head.too_short;
  assign out_name_char          = head.name_char;
  assign out_vendor_first_word  = head.vendor_first_word;
  assign out_vendor_second_word = head.vendor_second_word;
  assign out_vendor_third_word  = head.vendor_third_word;
  assign out_last_of_run        = head.last_of_run;

`ifndef ASSERT_OFF
  a_resync_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_buffer_last) |=> (phase_r == PH_LEN))
    else $error("parser did not resynchronize after the last buffer beat");

  a_open_record_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == PH_TYPE) || (phase_r == PH_PAYLOAD)) |-> (rem_r != 8'd0))
    else $error("open record with no bytes remaining");

  a_vendor_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= adsp_pkg::VIDX_W'(adsp_pkg::VENDOR_BYTES))
    else $error("vendor byte index out of range");
`endif

endmodule
